/* hw/rtl/s4p_pkg.sv */
// shared codes and types for the socks4a request parser
package s4p_pkg;

  typedef logic [2:0] phase_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] kind_t;

  localparam int unsigned FIXED_LEN = 8;

  localparam phase_t PH_FIXED   = 3'd0;
  localparam phase_t PH_USER    = 3'd1;
  localparam phase_t PH_DOMAIN  = 3'd2;
  localparam phase_t PH_PAYLOAD = 3'd3;
  localparam phase_t PH_DEAD    = 3'd4;

  localparam status_t ST_MORE    = 3'd0;
  localparam status_t ST_CONNECT = 3'd1;
  localparam status_t ST_BIND    = 3'd2;
  localparam status_t ST_BADCMD  = 3'd3;
  localparam status_t ST_TOOLONG = 3'd4;
  localparam status_t ST_PAYLOAD = 3'd5;
  localparam status_t ST_DEAD    = 3'd6;

  localparam kind_t KIND_NONE    = 2'd0;
  localparam kind_t KIND_DOMAIN  = 2'd1;
  localparam kind_t KIND_PAYLOAD = 2'd2;

  localparam logic [7:0] CMD_CONNECT = 8'd1;
  localparam logic [7:0] CMD_BIND    = 8'd2;

  localparam logic [8:0] HDR_LEN_MAX = 9'd511;

endpackage

/* hw/rtl/s4p_if.sv */
// request byte and parse result channel interfaces
interface s4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_request;

  modport source (output valid, output data_byte, output first_of_request, input ready);
  modport sink   (input valid, input data_byte, input first_of_request, output ready);
endinterface

interface s4p_out_if
  import s4p_pkg::*;
;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  command_code;
  logic [15:0] dest_port;
  logic [31:0] dest_ipv4;
  logic        is_domain;
  logic [7:0]  byte_out;
  kind_t       byte_kind;
  logic [8:0]  header_length;

  modport source (output valid, output status, output command_code, output dest_port,
                  output dest_ipv4, output is_domain, output byte_out, output byte_kind,
                  output header_length, input ready);
  modport sink   (input valid, input status, input command_code, input dest_port,
                  input dest_ipv4, input is_domain, input byte_out, input byte_kind,
                  input header_length, output ready);
endinterface

/* hw/rtl/socks4a_request_parser_top.sv */
// socks4a request parser: one byte in, one parse result out
// a result is registered in the output register in the cycle after its byte beat
// throughput: one byte per cycle while the output is not stalled; the output register is the only stage
// a stalled output register holds off the input until it drains
// reset (rst_n low, synchronous) returns the parser to the fixed header phase
// with counters and captured fields cleared and no result pending
module socks4a_request_parser_top
  import s4p_pkg::*;
#(
  parameter int unsigned MAX_HEADER = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  s4p_in_if.sink          in_ch,
  s4p_out_if.source       out_ch
);

  localparam int unsigned CW = $clog2(MAX_HEADER + 1);
  localparam int unsigned HW = (CW > 9) ? CW : 9;

  // parser state
  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [15:0]   port_r, port_nxt;
  logic [31:0]   addr_r, addr_nxt;

  // result register
  logic          out_valid_r;
  status_t       status_r, status_nxt;
  logic          is_domain_r, is_domain_nxt;
  logic [7:0]    byte_out_r, byte_out_nxt;
  kind_t         kind_r, kind_nxt;
  logic [8:0]    hlen_r, hlen_nxt;

  logic          in_beat;
  logic [7:0]    b;
  phase_t        ph;
  logic [CW-1:0] cnt;
  logic [7:0]    cmd;
  logic [15:0]   port;
  logic [31:0]   addr;
  logic [HW-1:0] cnt_wide;

  function automatic logic is_4a(input logic [31:0] a);
    return (a[31:8] == 24'd0) && (a[7:0] != 8'd0);
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    // a new request starts from a clean state
    ph   = in_ch.first_of_request ? PH_FIXED : phase_r;
    cnt  = in_ch.first_of_request ? '0 : cnt_r;
    cmd  = in_ch.first_of_request ? 8'd0 : cmd_r;
    port = in_ch.first_of_request ? 16'd0 : port_r;
    addr = in_ch.first_of_request ? 32'd0 : addr_r;

    phase_nxt    = ph;
    cnt_nxt      = cnt;
    cmd_nxt      = cmd;
    port_nxt     = port;
    addr_nxt     = addr;
    status_nxt   = ST_MORE;
    byte_out_nxt = 8'd0;
    kind_nxt     = KIND_NONE;

    unique case (ph)
      PH_FIXED: begin
        if (cnt == CW'(1)) begin
          cmd_nxt = b;
        end else if (cnt == CW'(2) || cnt == CW'(3)) begin
          port_nxt = {port[7:0], b};
        end else if (cnt >= CW'(4)) begin
          addr_nxt = {addr[23:0], b};
        end
        cnt_nxt = cnt + CW'(1);
        if (cnt == CW'(FIXED_LEN - 1)) begin
          phase_nxt = PH_USER;
        end
      end
      PH_USER, PH_DOMAIN: begin
        if (cnt == CW'(MAX_HEADER)) begin
          phase_nxt  = PH_DEAD;
          status_nxt = ST_TOOLONG;
        end else begin
          cnt_nxt = cnt + CW'(1);
          if (b == 8'd0) begin
            if (ph == PH_USER && is_4a(addr)) begin
              phase_nxt = PH_DOMAIN;
            end else if (cmd == CMD_CONNECT) begin
              phase_nxt  = PH_PAYLOAD;
              status_nxt = ST_CONNECT;
            end else if (cmd == CMD_BIND) begin
              phase_nxt  = PH_PAYLOAD;
              status_nxt = ST_BIND;
            end else begin
              phase_nxt  = PH_DEAD;
              status_nxt = ST_BADCMD;
            end
          end else if (ph == PH_DOMAIN) begin
            byte_out_nxt = b;
            kind_nxt     = KIND_DOMAIN;
          end
        end
      end
      PH_PAYLOAD: begin
        status_nxt   = ST_PAYLOAD;
        byte_out_nxt = b;
        kind_nxt     = KIND_PAYLOAD;
      end
      default: begin
        phase_nxt  = PH_DEAD;
        status_nxt = ST_DEAD;
      end
    endcase

    is_domain_nxt = (cnt_nxt >= CW'(FIXED_LEN)) && is_4a(addr_nxt);
    cnt_wide      = HW'(cnt_nxt);
    hlen_nxt      = (cnt_wide > HW'(HDR_LEN_MAX)) ? HDR_LEN_MAX : cnt_wide[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIXED;
      cnt_r       <= '0;
      cmd_r       <= 8'd0;
      port_r      <= 16'd0;
      addr_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        cmd_r   <= cmd_nxt;
        port_r  <= port_nxt;
        addr_r  <= addr_nxt;
      end
      if (in_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      status_r    <= status_nxt;
      is_domain_r <= is_domain_nxt;
      byte_out_r  <= byte_out_nxt;
      kind_r      <= kind_nxt;
      hlen_r      <= hlen_nxt;
    end
  end

  // captured fields are shown as held in the parser state
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.command_code  = cmd_r;
  assign out_ch.dest_port     = port_r;
  assign out_ch.dest_ipv4     = addr_r;
  assign out_ch.is_domain     = is_domain_r;
  assign out_ch.byte_out      = byte_out_r;
  assign out_ch.byte_kind     = kind_r;
  assign out_ch.header_length = hlen_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_HEADER))
    else $error("header byte count beyond limit");

  a_fixed_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIXED) |-> (cnt_r < CW'(FIXED_LEN)))
    else $error("fixed header phase with full header count");

  a_payload_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (cmd_r == CMD_CONNECT || cmd_r == CMD_BIND))
    else $error("payload phase after a rejected command");

  a_domain_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DOMAIN) |-> is_4a(addr_r))
    else $error("domain phase without a socks4a address");

  a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_PAYLOAD) |-> (status_r == ST_PAYLOAD))
    else $error("payload byte forwarded with wrong status");
`endif

endmodule
